// ===== design/slp_pkg.sv =====
// Shared types and constants for the stereo looping sample player.
// Used by every module of the design but slp_ram; depends on nothing.
package slp_pkg;

	localparam int TABLE_FRAMES = 65536;
	localparam int ADDR_W = $clog2(TABLE_FRAMES);
	localparam int FRAC_W = 16;
	localparam int SAMPLE_W = 16;
	localparam int PHASE_W = 34;
	localparam int FRM_W = 17;
	localparam int MODN_W = PHASE_W - FRAC_W;
	localparam int MODC_W = $clog2(MODN_W + 1);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 33;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_PLAY = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 3'd5;

	typedef struct packed {
		logic [1:0] action;
		logic [ADDR_W-1:0] addr;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic signed [SAMPLE_W-1:0] gain;
	} slp_item_t;

	typedef struct packed {
		logic [15:0] loop_start;
		logic [15:0] loop_end;
		logic signed [31:0] phase_step;
		logic signed [32:0] start_phase;
		logic [FRM_W-1:0] frames;
		logic interp;
	} slp_cfg_t;

	typedef struct packed {
		logic phase_neg;
		logic mod_busy;
		logic mod_wait;
	} slp_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_MIX,
		ST_GAIN,
		ST_RST,
		ST_ADV,
		ST_MOD,
		ST_FIN,
		ST_OUT
	} slp_state_t;

endpackage

// ===== design/slp_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module slp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/slp_mod.sv =====
// Iterative remainder unit: one quotient bit per cycle, frame domain.
// Depends on slp_pkg.
module slp_mod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [slp_pkg::MODN_W-1:0]     num,
	input  logic [slp_pkg::FRM_W-1:0]      den,
	output logic                           busy,
	output logic                           done,
	output logic [slp_pkg::FRM_W-1:0]      rem
);

	logic [slp_pkg::FRM_W-1:0] r_q;
	logic [slp_pkg::MODN_W-1:0] n_q;
	logic [slp_pkg::MODC_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [slp_pkg::FRM_W:0] trial;
	logic [slp_pkg::FRM_W:0] diff;

	assign trial = {r_q, n_q[slp_pkg::MODN_W-1]};
	assign diff = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= slp_pkg::MODC_W'(slp_pkg::MODN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == slp_pkg::MODC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			n_q <= num;
		end else if (busy_q) begin
			// restore when the trial subtract goes negative
			r_q <= diff[slp_pkg::FRM_W] ? trial[slp_pkg::FRM_W-1:0] :
				diff[slp_pkg::FRM_W-1:0];
			n_q <= {n_q[slp_pkg::MODN_W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem = r_q;

endmodule

// ===== design/slp_front.sv =====
// Front end: accepts items, drops ACT_NONE items, queues the rest.
// Depends on slp_pkg.
module slp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  slp_pkg::slp_item_t    in_item,
	output logic                  q_valid,
	output slp_pkg::slp_item_t    q_item,
	input  logic                  q_pop
);

	slp_pkg::slp_item_t entry_q [2];
	logic [1:0] count_q;
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic push;
	logic pop;

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall && (in_item.action != slp_pkg::ACT_NONE);
	assign pop = q_pop && (count_q != 2'd0);
	assign q_valid = (count_q != 2'd0);
	assign q_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

// ===== design/slp_engine.sv =====
// Back end: table writes, restarts, playback with interpolation and gain, phase wrap.
// Depends on slp_pkg, slp_ram and slp_mod.
module slp_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slp_pkg::slp_cfg_t            cfg,
	input  logic                         q_valid,
	input  slp_pkg::slp_item_t           q_item,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [slp_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [slp_pkg::SAMPLE_W-1:0] right_out,
	output slp_pkg::slp_status_t         status
);

	localparam int F = slp_pkg::FRAC_W;
	localparam int S = slp_pkg::SAMPLE_W;
	localparam int P = slp_pkg::PHASE_W;
	localparam int N = slp_pkg::FRM_W;
	localparam int A = slp_pkg::ADDR_W;

	slp_pkg::slp_state_t state_q, state_d;

	logic signed [P-1:0] phase_q;
	logic signed [P-1:0] x_q;
	logic signed [S-1:0] gain_q;
	logic play_q;
	logic high_q;
	logic [F-1:0] frac_q;
	logic out_valid_q;
	logic signed [S-1:0] left_q, right_q;

	logic signed [S-1:0] f0l_q, f0r_q;
	logic f1_zero_q;
	logic signed [2*S+1:0] mixl_s1, mixr_s1;
	logic signed [2*S:0] gl_s2, gr_s2;

	// loop bounds
	logic [N-1:0] n_cl, lo, hi, b0, len;
	logic signed [P-1:0] lo_q16, hi_q16;

	always_comb begin
		n_cl = cfg.frames;
		if (n_cl < N'(3)) begin
			n_cl = N'(3);
		end
		if (n_cl > N'(slp_pkg::TABLE_FRAMES)) begin
			n_cl = N'(slp_pkg::TABLE_FRAMES);
		end
		lo = {1'b0, cfg.loop_start};
		if (lo > n_cl - N'(3)) begin
			lo = n_cl - N'(3);
		end
		b0 = {1'b0, cfg.loop_end};
		if (b0 > n_cl - N'(1)) begin
			b0 = n_cl - N'(1);
		end else if (b0 <= N'(2)) begin
			b0 = N'(2);
		end
		hi = (b0 < lo + N'(2)) ? lo + N'(2) : b0;
		len = hi - lo;
		lo_q16 = $signed({{(P-N-F){1'b0}}, lo, {F{1'b0}}});
		hi_q16 = $signed({{(P-N-F){1'b0}}, hi, {F{1'b0}}});
	end

	// table
	logic ram_we;
	logic [A-1:0] ram_raddr;
	logic [2*S-1:0] ram_rdata;
	logic [A-1:0] ip;
	logic [A:0] ip1;
	logic [F-1:0] fr;

	assign ip = phase_q[F+A-1:F];
	assign ip1 = {1'b0, ip} + 1'b1;
	assign fr = phase_q[F-1:0];

	slp_ram #(.WIDTH(2 * S), .DEPTH(slp_pkg::TABLE_FRAMES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (q_item.addr),
		.wdata ({q_item.left, q_item.right}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// remainder unit
	logic mod_start, mod_busy, mod_done;
	logic [N-1:0] mod_rem;
	logic signed [P-1:0] diff_hi, diff_lo, diff_sel;
	logic in_high, in_low;

	assign diff_hi = x_q - hi_q16;
	assign diff_lo = lo_q16 - x_q;
	assign in_high = (x_q >= hi_q16);
	assign in_low = (x_q < lo_q16) && play_q;
	assign diff_sel = in_high ? diff_hi : diff_lo;

	slp_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.num    (diff_sel[P-1:F]),
		.den    (len),
		.busy   (mod_busy),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	// next phase candidates
	logic signed [P-1:0] x_interp, x_int;
	logic signed [N:0] istep;
	logic signed [N+1:0] ipsum;

	always_comb begin
		istep = (N+1)'(cfg.phase_step >>> F);
		if (cfg.phase_step[31] && (cfg.phase_step[F-1:0] != '0)) begin
			istep = istep + (N+1)'(1);
		end
		ipsum = $signed({2'b00, ip}) + (N+2)'(istep);
		x_int = $signed({ipsum[P-F-1:0], {F{1'b0}}});
		x_interp = phase_q + P'(cfg.phase_step);
	end

	// wrap result
	logic [N+F-1:0] rem_q16;
	logic signed [P-1:0] wrapped;

	always_comb begin
		rem_q16 = {mod_rem, frac_q};
		if (high_q) begin
			wrapped = lo_q16 + $signed({{(P-N-F){1'b0}}, rem_q16});
		end else if (rem_q16 == '0) begin
			wrapped = lo_q16;
		end else begin
			wrapped = hi_q16 - $signed({{(P-N-F){1'b0}}, rem_q16});
		end
	end

	// mix and gain
	logic signed [S-1:0] f1l, f1r;
	logic signed [S:0] dl, dr;
	logic signed [P-F-1:0] sl_w, sr_w;
	logic signed [S:0] sl, sr;
	logic out_free;

	assign f1l = f1_zero_q ? '0 : $signed(ram_rdata[2*S-1:S]);
	assign f1r = f1_zero_q ? '0 : $signed(ram_rdata[S-1:0]);
	assign dl = f1l - f0l_q;
	assign dr = f1r - f0r_q;
	assign sl_w = $signed({{2{f0l_q[S-1]}}, f0l_q}) + mixl_s1[2*S+1:F];
	assign sr_w = $signed({{2{f0r_q[S-1]}}, f0r_q}) + mixr_s1[2*S+1:F];
	assign sl = cfg.interp ? sl_w[S:0] : {f0l_q[S-1], f0l_q};
	assign sr = cfg.interp ? sr_w[S:0] : {f0r_q[S-1], f0r_q};
	assign out_free = !out_valid_q || !out_stall;

	function automatic logic signed [S-1:0] sat_out(input logic signed [2*S:0] p);
		logic signed [S+1:0] q;
		begin
			q = p[2*S:S-1];
			if (q > $signed((S+2)'((1 << (S - 1)) - 1))) begin
				sat_out = {1'b0, {(S-1){1'b1}}};
			end else if (q < -$signed((S+2)'(1 << (S - 1)))) begin
				sat_out = {1'b1, {(S-1){1'b0}}};
			end else begin
				sat_out = q[S-1:0];
			end
		end
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slp_pkg::ST_IDLE: begin
				if (q_valid) begin
					priority case (q_item.action)
						slp_pkg::ACT_PLAY: state_d = slp_pkg::ST_RD0;
						slp_pkg::ACT_RESTART: state_d = slp_pkg::ST_RST;
						default: state_d = slp_pkg::ST_IDLE;
					endcase
				end
			end
			slp_pkg::ST_RD0: state_d = slp_pkg::ST_RD1;
			slp_pkg::ST_RD1: state_d = slp_pkg::ST_MIX;
			slp_pkg::ST_MIX: state_d = slp_pkg::ST_GAIN;
			slp_pkg::ST_GAIN: state_d = slp_pkg::ST_ADV;
			slp_pkg::ST_RST: state_d = slp_pkg::ST_ADV;
			slp_pkg::ST_ADV: begin
				if (in_high || in_low) begin
					state_d = slp_pkg::ST_MOD;
				end else begin
					state_d = play_q ? slp_pkg::ST_OUT : slp_pkg::ST_IDLE;
				end
			end
			slp_pkg::ST_MOD: begin
				if (mod_done) begin
					state_d = slp_pkg::ST_FIN;
				end
			end
			slp_pkg::ST_FIN: state_d = play_q ? slp_pkg::ST_OUT : slp_pkg::ST_IDLE;
			slp_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = slp_pkg::ST_IDLE;
				end
			end
			default: state_d = slp_pkg::ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		q_pop = 1'b0;
		ram_we = 1'b0;
		ram_raddr = ip;
		mod_start = 1'b0;
		unique case (state_q)
			slp_pkg::ST_IDLE: begin
				q_pop = q_valid;
				ram_we = q_valid && (q_item.action == slp_pkg::ACT_WRITE);
			end
			slp_pkg::ST_RD1: ram_raddr = ip1[A-1:0];
			slp_pkg::ST_ADV: mod_start = in_high || in_low;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slp_pkg::ST_IDLE;
			phase_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == slp_pkg::ST_ADV && !(in_high || in_low)) begin
				phase_q <= x_q;
			end else if (state_q == slp_pkg::ST_FIN) begin
				phase_q <= wrapped;
			end
			if (state_q == slp_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == slp_pkg::ST_IDLE && q_valid) begin
			gain_q <= q_item.gain;
			play_q <= (q_item.action == slp_pkg::ACT_PLAY);
		end
		if (state_q == slp_pkg::ST_RD1) begin
			f0l_q <= $signed(ram_rdata[2*S-1:S]);
			f0r_q <= $signed(ram_rdata[S-1:0]);
			f1_zero_q <= ip1[A];
		end
		if (state_q == slp_pkg::ST_MIX) begin
			mixl_s1 <= dl * $signed({1'b0, fr});
			mixr_s1 <= dr * $signed({1'b0, fr});
		end
		if (state_q == slp_pkg::ST_GAIN) begin
			gl_s2 <= sl * gain_q;
			gr_s2 <= sr * gain_q;
			x_q <= cfg.interp ? x_interp : x_int;
		end
		if (state_q == slp_pkg::ST_RST) begin
			// keep the current phase when the restart register is negative
			x_q <= cfg.start_phase[32] ? phase_q : P'(cfg.start_phase);
		end
		if (state_q == slp_pkg::ST_ADV) begin
			high_q <= in_high;
			frac_q <= diff_sel[F-1:0];
		end
		if (state_q == slp_pkg::ST_OUT && out_free) begin
			left_q <= sat_out(gl_s2);
			right_q <= sat_out(gr_s2);
		end
	end

	assign out_valid = out_valid_q;
	assign left_out = left_q;
	assign right_out = right_q;
	assign status.phase_neg = phase_q[P-1];
	assign status.mod_busy = mod_busy;
	assign status.mod_wait = (state_q == slp_pkg::ST_MOD);

endmodule

// ===== design/stereo_looping_sample_player_core.sv =====
// Channel  Handshake          Payload
// in       in_valid/in_stall  action, frame_address, left_sample, right_sample, gain
// out      out_valid/out_stall left_out, right_out
// cfg      cfg_we             cfg_index, cfg_data
// In the back end a write is done in IDLE, a restart runs RST and ADV, a play
// RD0, RD1, MIX, GAIN, ADV and OUT. When the new phase leaves the loop, the
// remainder unit adds MOD and FIN (one quotient bit per cycle over 18 frame bits).
// arst_n clears phase and queue, resets config to defaults; table stays undefined.
// A two-entry queue takes items while the back end or out_stall holds, until full.
// Top level: configuration registers, front queue and back-end engine.
// Depends on slp_pkg, slp_front and slp_engine.
module stereo_looping_sample_player_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           action,
	input  logic [slp_pkg::ADDR_W-1:0]           frame_address,
	input  logic signed [slp_pkg::SAMPLE_W-1:0]  left_sample,
	input  logic signed [slp_pkg::SAMPLE_W-1:0]  right_sample,
	input  logic signed [slp_pkg::SAMPLE_W-1:0]  gain,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [slp_pkg::SAMPLE_W-1:0]  left_out,
	output logic signed [slp_pkg::SAMPLE_W-1:0]  right_out,
	input  logic                                 cfg_we,
	input  logic [slp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [slp_pkg::CFG_DATA_W-1:0]       cfg_data
);

	slp_pkg::slp_cfg_t cfg_q;
	slp_pkg::slp_item_t in_item;
	slp_pkg::slp_item_t q_item;
	slp_pkg::slp_status_t status;
	logic q_valid;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loop_start <= 16'd0;
			cfg_q.loop_end <= 16'd2;
			cfg_q.phase_step <= 32'sd65536;
			cfg_q.start_phase <= '0;
			cfg_q.frames <= slp_pkg::FRM_W'(slp_pkg::TABLE_FRAMES);
			cfg_q.interp <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slp_pkg::CFG_LOOP_START: cfg_q.loop_start <= cfg_data[15:0];
				slp_pkg::CFG_LOOP_END: cfg_q.loop_end <= cfg_data[15:0];
				slp_pkg::CFG_PHASE_STEP: cfg_q.phase_step <= $signed(cfg_data[31:0]);
				slp_pkg::CFG_START_PHASE: cfg_q.start_phase <= $signed(cfg_data);
				slp_pkg::CFG_FRAMES: cfg_q.frames <= cfg_data[slp_pkg::FRM_W-1:0];
				slp_pkg::CFG_INTERP: cfg_q.interp <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_item.action = action;
	assign in_item.addr = frame_address;
	assign in_item.left = left_sample;
	assign in_item.right = right_sample;
	assign in_item.gain = gain;

	slp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	slp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.left_out  (left_out),
		.right_out (right_out),
		.status    (status)
	);

`ifndef NO_ASSERTIONS
	a_phase_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!status.phase_neg)
		else $error("play phase went negative");

	a_mod_owned: assert property (@(posedge clk) disable iff (!arst_n)
		status.mod_busy |-> status.mod_wait)
		else $error("remainder unit busy outside its wait state");

	a_mod_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(status.mod_busy) |-> status.mod_wait)
		else $error("remainder finished with no one waiting");
`endif

endmodule
